// ----- src/apbo_pkg.sv -----
package apbo_pkg;

	// Action codes carried in s_tuser.
	localparam logic [2:0] ACT_SET   = 3'd0;
	localparam logic [2:0] ACT_CLEAR = 3'd1;
	localparam logic [2:0] ACT_TEST  = 3'd2;
	localparam logic [2:0] ACT_NEXT  = 3'd3;
	localparam logic [2:0] ACT_LAST  = 3'd4;
	localparam logic [2:0] ACT_FULL  = 3'd5;

	// Register indexes on the configuration port.
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	localparam int unsigned SIZE_W  = 11;
	localparam int unsigned COUNT_W = 64;
	localparam int unsigned ADDR_W  = 32;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] size;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [COUNT_W-1:0] num;
		logic [SIZE_W-1:0]  den;
	} div_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_DIV,
		ST_PUSH
	} state_t;

endpackage

// ----- src/apbo_ram.sv -----
module apbo_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/apbo_divider.sv -----
module apbo_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  apbo_pkg::div_req_t req,
	output logic              done,
	output logic [apbo_pkg::ADDR_W-1:0] rem
);

	logic [apbo_pkg::COUNT_W-1:0] num_q;
	logic [apbo_pkg::SIZE_W-1:0]  den_q;
	logic [apbo_pkg::SIZE_W-1:0]  r_q;
	logic [5:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [apbo_pkg::SIZE_W:0]    trial;
	logic [apbo_pkg::SIZE_W:0]    diff;
	logic [apbo_pkg::SIZE_W-1:0]  r_next;

	// One restoring step: bring in the next numerator bit, subtract if it fits.
	always_comb begin
		trial  = {r_q, num_q[apbo_pkg::COUNT_W-1]};
		diff   = trial - {1'b0, den_q};
		r_next = (trial >= {1'b0, den_q}) ? diff[apbo_pkg::SIZE_W-1:0]
		                                  : trial[apbo_pkg::SIZE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The numerator rotates, so after 64 steps it holds its original value again.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			r_q   <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[apbo_pkg::COUNT_W-2:0], num_q[apbo_pkg::COUNT_W-1]};
			r_q   <= r_next;
		end
	end

	// With a zero divisor the remainder is the low ADDR_W bits of the numerator itself.
	assign rem  = (den_q == '0) ? num_q[apbo_pkg::ADDR_W-1:0]
	                            : {{(apbo_pkg::ADDR_W - apbo_pkg::SIZE_W){1'b0}}, r_q};
	assign done = done_q;

endmodule

// ----- src/apbo_regs.sv -----
module apbo_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output apbo_pkg::cfg_t      cfg
);

	logic                        wr_en;
	logic [apbo_pkg::ADDR_W-1:0] base_q;
	logic [apbo_pkg::SIZE_W-1:0] size_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= apbo_pkg::SIZE_W'(1);
		end else if (wr_en) begin
			unique case (paddr[2])
				apbo_pkg::REG_BASE: base_q <= pwdata;
				apbo_pkg::REG_SIZE: size_q <= pwdata[apbo_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			apbo_pkg::REG_BASE: prdata = base_q;
			apbo_pkg::REG_SIZE: prdata = {{(32 - apbo_pkg::SIZE_W){1'b0}}, size_q};
			default:            prdata = '0;
		endcase
	end

	assign cfg.base = base_q;
	assign cfg.size = size_q;

endmodule

// ----- src/address_pool_bitmap_offer.sv -----
// Address pool engine for one lease range.
// Commands arrive on the slave stream: s_tuser carries the action (set used, clear,
// test, next offer, last offer, range-full check), s_tdata carries the slot offset
// and the probe address. Each command beat yields exactly one result beat on the
// master stream, in order. The user must write the range base and size over the APB
// port only while no command is in flight; the block itself does not enforce it.
// The used map lives in a synchronous RAM of POOL_BITS/32 words. Set and clear read
// the word and write it back in the following cycle; a test reads it the same way.
// Those commands go through the map state, then the push state, to the output
// register; the ones that need no lookup go straight to the push state. No new
// command is taken until the push state has handed its result on. An offer computes
// the counter modulo the pool size in a one-bit-per-cycle restoring divider: a next
// offer, or a last offer once an offer has been made, goes through the divide state,
// where the 64-step loop runs, then the push state, so that loop sets the throughput
// for offers. After reset the map is cleared by a sweep that writes one word per
// cycle, during which s_tready stays low. The offer counter resets to zero, the base
// to 0 and the size to 1.
// Results sit in an output register. A new command is accepted while a result still
// waits there; when the receiver stalls, the next result waits in its own stage and
// the engine stops accepting until the output register frees up.
module address_pool_bitmap_offer #(
	parameter int unsigned POOL_BITS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Command stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // action
	input  logic [47:0] s_tdata,  // [15:0] slot_offset, [47:16] probe_address
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // [0] slot_used, [32:1] offer_address,
	                              // [33] range_is_full, [34] ignored, [39:35] zero
);

	localparam int unsigned MAP_WORDS = (POOL_BITS + 31) / 32;
	localparam int unsigned WI        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam logic [WI-1:0] LAST_WORD = WI'(MAP_WORDS - 1);

	apbo_pkg::cfg_t     cfg;
	apbo_pkg::state_t   state_q, state_d;
	apbo_pkg::div_req_t div_req;
	logic               div_done;
	logic [31:0]        div_rem;

	logic [WI-1:0] clr_q;
	logic          accept;
	logic          out_free;

	logic [15:0]   in_offset;
	logic [31:0]   in_probe;
	logic          in_map;
	logic [31:0]   probe_diff;

	logic          ram_we;
	logic [WI-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	logic [apbo_pkg::COUNT_W-1:0] count_q;

	// Command held while it is worked on.
	logic [2:0]    act_q;
	logic [WI-1:0] word_q;
	logic [4:0]    bit_q;

	// Result stage, then the output register.
	logic          res_used_q, res_full_q, res_ign_q;
	logic [31:0]   res_offer_q;
	logic          m_tvalid_q;
	logic [39:0]   m_tdata_q;

	apbo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	apbo_ram #(
		.WIDTH (32),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (in_offset[5 +: WI]),
		.rdata (ram_rdata)
	);

	apbo_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.rem    (div_rem)
	);

	assign in_offset  = s_tdata[15:0];
	assign in_probe   = s_tdata[47:16];
	assign in_map     = {1'b0, in_offset} < 17'(POOL_BITS);
	assign probe_diff = in_probe - cfg.base;

	assign s_tready = (state_q == apbo_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// The divider starts on the accepted offer command; a last offer works on the
	// counter value before the most recent increment.
	assign div_req.start = accept && ((s_tuser == apbo_pkg::ACT_NEXT)
	                       || ((s_tuser == apbo_pkg::ACT_LAST) && (count_q != '0)));
	assign div_req.num   = (s_tuser == apbo_pkg::ACT_NEXT) ? count_q
	                                                      : count_q - 64'd1;
	assign div_req.den   = cfg.size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apbo_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			apbo_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == LAST_WORD) begin
					state_d = apbo_pkg::ST_IDLE;
				end
			end
			apbo_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (s_tuser)
						apbo_pkg::ACT_SET, apbo_pkg::ACT_CLEAR:
							state_d = in_map ? apbo_pkg::ST_MAP : apbo_pkg::ST_PUSH;
						apbo_pkg::ACT_TEST:
							state_d = (in_map && ({5'b0, cfg.size} > in_offset))
							          ? apbo_pkg::ST_MAP : apbo_pkg::ST_PUSH;
						apbo_pkg::ACT_NEXT:
							state_d = apbo_pkg::ST_DIV;
						apbo_pkg::ACT_LAST:
							state_d = (count_q != '0) ? apbo_pkg::ST_DIV
							                          : apbo_pkg::ST_PUSH;
						default:
							state_d = apbo_pkg::ST_PUSH;
					endcase
				end
			end
			apbo_pkg::ST_MAP: begin
				// Read data of the word addressed at accept is here now.
				if (act_q == apbo_pkg::ACT_SET) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | (32'd1 << bit_q);
				end else if (act_q == apbo_pkg::ACT_CLEAR) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata & ~(32'd1 << bit_q);
				end
				state_d = apbo_pkg::ST_PUSH;
			end
			apbo_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = apbo_pkg::ST_PUSH;
				end
			end
			apbo_pkg::ST_PUSH: begin
				if (out_free) begin
					state_d = apbo_pkg::ST_IDLE;
				end
			end
			default: state_d = apbo_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == apbo_pkg::ST_CLEAR) begin
				clr_q <= clr_q + WI'(1);
			end
			if (accept && (s_tuser == apbo_pkg::ACT_NEXT)) begin
				count_q <= count_q + 64'd1;
			end
			if ((state_q == apbo_pkg::ST_PUSH) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q       <= s_tuser;
			word_q      <= in_offset[5 +: WI];
			bit_q       <= in_offset[4:0];
			res_offer_q <= '0;
			res_ign_q   <= ((s_tuser == apbo_pkg::ACT_SET) || (s_tuser == apbo_pkg::ACT_CLEAR))
			               && !in_map;
			// A test outside the pool, or beyond the map, reads as used.
			res_used_q  <= (s_tuser == apbo_pkg::ACT_TEST)
			               && (!in_map || ({5'b0, cfg.size} <= in_offset));
			res_full_q  <= (s_tuser == apbo_pkg::ACT_FULL) && (in_probe >= cfg.base)
			               && (probe_diff == ({21'b0, cfg.size} - 32'd1));
		end
		if ((state_q == apbo_pkg::ST_MAP) && (act_q == apbo_pkg::ACT_TEST)) begin
			res_used_q <= ram_rdata[bit_q];
		end
		if ((state_q == apbo_pkg::ST_DIV) && div_done) begin
			res_offer_q <= cfg.base + div_rem;
		end
		if ((state_q == apbo_pkg::ST_PUSH) && out_free) begin
			m_tdata_q <= {5'b0, res_ign_q, res_full_q, res_offer_q, res_used_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the address pool engine. Commands go in on the slave stream;
// each accepted beat runs through a local copy of the pool (used bits, offer
// counter, base and size), and the predicted result waits in a queue until the
// engine's result beat arrives. The result is then compared field by field.
// The configuration port is written only while nothing is in flight.
module tb_top;

	localparam int POOL_BITS = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 600;

	// Action codes 6 and 7 are not assigned; the engine must treat them as no-ops.
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	// Byte addresses of the two registers on the configuration port.
	localparam logic [2:0] ADDR_BASE = {apbo_pkg::REG_BASE, 2'b00};
	localparam logic [2:0] ADDR_SIZE = {apbo_pkg::REG_SIZE, 2'b00};

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] offset;
		logic [31:0] probe;
	} pool_cmd_t;

	typedef struct packed {
		logic        ign;
		logic        full;
		logic [31:0] offer;
		logic        used;
	} pool_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [2:0]  s_tuser = '0;  // action
	logic [47:0] s_tdata = '0;  // [15:0] slot_offset, [47:16] probe_address
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // [0] slot_used, [32:1] offer_address,
	                            // [33] range_is_full, [34] ignored, [39:35] zero

	address_pool_bitmap_offer #(
		.POOL_BITS(POOL_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	// Local copy of the pool. The configuration fields mirror what was last
	// written over the configuration port.
	logic [POOL_BITS-1:0] lease_map = '0;
	logic [63:0]          lease_count = '0;
	logic [31:0]          cfg_base = '0;
	logic [10:0]          cfg_size = 11'd1;

	pool_cmd_t    cmd_q[$];
	pool_result_t pending_results[$];
	pool_cmd_t    drive_cmd;

	logic cmd_taken = 1'b0;
	int   burst_left = 0;
	int   gap_left = 0;
	int   hold_asked = 0;
	int   hold_taken = 0;
	int   hold_left = 0;
	int   rx_cycle = 0;
	int   cycle_count = 0;
	int   mismatches = 0;
	int   results_checked = 0;
	int   pool_settings = 0;
	int   act_beats[8];

	// The offer for a given counter value: base plus counter modulo size. With a
	// zero size the division leaves the counter itself as the remainder.
	function automatic logic [31:0] offer_at(input logic [63:0] count);
		logic [63:0] rem;
		rem = (cfg_size == 0) ? count : count % {53'd0, cfg_size};
		return cfg_base + rem[31:0];
	endfunction

	// Applies one command to the local pool and returns the result beat that the
	// engine has to produce for it.
	function automatic pool_result_t pool_apply(input pool_cmd_t c);
		pool_result_t r;
		logic in_map;
		r = '0;
		in_map = c.offset < POOL_BITS;
		case (c.action)
		apbo_pkg::ACT_SET: begin
			if (in_map) lease_map[c.offset] = 1'b1;
			else r.ign = 1'b1;
		end
		apbo_pkg::ACT_CLEAR: begin
			if (in_map) lease_map[c.offset] = 1'b0;
			else r.ign = 1'b1;
		end
		apbo_pkg::ACT_TEST: begin
			// Anything past the range or past the map reads as taken.
			if (c.offset >= cfg_size || !in_map) r.used = 1'b1;
			else r.used = lease_map[c.offset];
		end
		apbo_pkg::ACT_NEXT: begin
			r.offer = offer_at(lease_count);
			lease_count = lease_count + 64'd1;
		end
		apbo_pkg::ACT_LAST: begin
			if (lease_count != 0) r.offer = offer_at(lease_count - 64'd1);
		end
		apbo_pkg::ACT_FULL: begin
			// A probe below the base never counts as the last address.
			if (c.probe >= cfg_base)
				r.full = ((c.probe - cfg_base) == (32'(cfg_size) - 32'd1));
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic pool_cmd_t random_cmd();
		pool_cmd_t c;
		int span;
		int pick;
		span = (cfg_size == 0) ? 1 : ((cfg_size > POOL_BITS) ? POOL_BITS : int'(cfg_size));
		pick = $urandom_range(0, 99);
		if (pick < 22) c.action = apbo_pkg::ACT_SET;
		else if (pick < 36) c.action = apbo_pkg::ACT_CLEAR;
		else if (pick < 60) c.action = apbo_pkg::ACT_TEST;
		else if (pick < 74) c.action = apbo_pkg::ACT_NEXT;
		else if (pick < 82) c.action = apbo_pkg::ACT_LAST;
		else if (pick < 97) c.action = apbo_pkg::ACT_FULL;
		else c.action = pick[0] ? ACT_SPARE_6 : ACT_SPARE_7;
		// Mostly offsets inside the range, some right at its edge, a few anywhere.
		case ($urandom_range(0, 9))
		0: c.offset = 16'($urandom_range(0, 65535));
		1: c.offset = 16'(span - 2 + int'($urandom_range(0, 3)));
		default: c.offset = 16'($urandom_range(0, span - 1));
		endcase
		// Probes favor the last address of the range and its neighborhood.
		case ($urandom_range(0, 3))
		0: c.probe = $urandom;
		1: c.probe = cfg_base + 32'($urandom_range(0, 2 * span)) - 32'd4;
		default: c.probe = cfg_base + 32'(cfg_size) - 32'd1;
		endcase
		return c;
	endfunction

	task automatic push_cmd(input logic [2:0] action, input logic [15:0] offset,
			input logic [31:0] probe);
		pool_cmd_t c;
		c.action = action;
		c.offset = offset;
		c.probe = probe;
		cmd_q.push_back(c);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_pool(input logic [31:0] base, input logic [10:0] size);
		reg_write(ADDR_BASE, base);
		reg_write(ADDR_SIZE, {21'd0, size});
		cfg_base = base;
		cfg_size = size;
		pool_settings++;
	endtask

	// Waits until every queued command has been taken and every predicted
	// result has come back, then lets the engine settle.
	task automatic drain();
		while (cmd_q.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
					$time, name, want, got);
		end
	endtask

	// Command driver. It sends in bursts of random length separated by random
	// gaps; a gap of zero gives stretches of back-to-back beats. A beat stays on
	// the bus until the cycle after it was taken.
	always @(negedge clk) begin
		if (!s_tvalid || cmd_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				drive_cmd = cmd_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drive_cmd.action;
				s_tdata <= {drive_cmd.probe, drive_cmd.offset};
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver. The stall pattern rotates through four modes: always ready,
	// coin flip, mostly stalled, and a regular on/off rhythm. On request it also
	// holds off for a long stretch so that the engine backs up into its input.
	always @(negedge clk) begin
		if (hold_taken != hold_asked) begin
			hold_taken++;
			hold_left = LONG_HOLD;
		end
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case ((rx_cycle / 256) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((rx_cycle % 8) >= 2);
			endcase
		end
	end

	// Monitor. Values are read at the rising edge before the engine updates its
	// outputs, so both streams see exactly the handshakes that the engine saw.
	// An accepted command is predicted right away; an accepted result is
	// checked against the oldest prediction.
	always @(posedge clk) begin
		pool_cmd_t    seen_cmd;
		pool_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			cmd_taken <= arst_n && s_tvalid && s_tready;
			if (arst_n && s_tvalid && s_tready) begin
				seen_cmd.action = s_tuser;
				seen_cmd.offset = s_tdata[15:0];
				seen_cmd.probe = s_tdata[47:16];
				act_beats[s_tuser]++;
				pending_results.push_back(pool_apply(seen_cmd));
			end
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t ns: result beat with nothing expected, got 0x%0h",
						$time, m_tdata);
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					check_field("slot_used", 32'(want.used), 32'(m_tdata[0]));
					check_field("offer_address", want.offer, m_tdata[32:1]);
					check_field("range_is_full", 32'(want.full), 32'(m_tdata[33]));
					check_field("ignored", 32'(want.ign), 32'(m_tdata[34]));
					check_field("pad bits", 32'd0, 32'(m_tdata[39:35]));
				end
			end
		end
	end

	// Stimulus: reset, a directed pass over the corner cases, then random
	// phases under a series of pool settings.
	initial begin
		int phase;
		int k;
		logic [31:0] base;
		logic [10:0] size;
		for (k = 0; k < 8; k++) act_beats[k] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings are base 0 and size 1. The first command asks for the
		// last offer before any offer was made.
		push_cmd(apbo_pkg::ACT_LAST, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_TEST, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_TEST, 16'hFFFF, 32'hFFFF_FFFF);
		push_cmd(apbo_pkg::ACT_NEXT, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_LAST, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_FULL, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_FULL, 16'd0, 32'hFFFF_FFFF);
		push_cmd(ACT_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF);
		push_cmd(ACT_SPARE_7, 16'hFFFF, 32'hFFFF_FFFF);
		drain();

		// Full-size map at the top of the address space: offers wrap past zero,
		// and set or clear beyond the map is flagged and ignored.
		set_pool(32'hFFFF_FFFF, 11'd1024);
		push_cmd(apbo_pkg::ACT_SET, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_SET, 16'd1023, 32'd0);
		push_cmd(apbo_pkg::ACT_SET, 16'd1024, 32'd0);
		push_cmd(apbo_pkg::ACT_CLEAR, 16'hFFFF, 32'd0);
		push_cmd(apbo_pkg::ACT_TEST, 16'd1023, 32'd0);
		push_cmd(apbo_pkg::ACT_CLEAR, 16'd1023, 32'd0);
		push_cmd(apbo_pkg::ACT_TEST, 16'd1023, 32'd0);
		push_cmd(apbo_pkg::ACT_TEST, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_NEXT, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_LAST, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_FULL, 16'd0, 32'd0);
		drain();

		// A zero size: every test reads taken, offers use the raw counter, and
		// only a probe at base minus one (wrapped) is the last address.
		set_pool(32'd0, 11'd0);
		push_cmd(apbo_pkg::ACT_TEST, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_NEXT, 16'd0, 32'd0);
		push_cmd(apbo_pkg::ACT_FULL, 16'd0, 32'hFFFF_FFFF);
		drain();

		// A size larger than the map: offsets past the map read as taken.
		set_pool(32'd0, 11'd2047);
		push_cmd(apbo_pkg::ACT_TEST, 16'd1024, 32'd0);
		push_cmd(apbo_pkg::ACT_TEST, 16'd1000, 32'd0);
		push_cmd(apbo_pkg::ACT_FULL, 16'd0, 32'd2046);
		drain();

		for (phase = 0; phase < 10; phase++) begin
			case (phase)
			0: size = 11'd1;
			1: size = 11'd2;
			2: size = 11'd1024;
			3: size = 11'd0;
			4: size = 11'd2047;
			5: size = 11'd3;
			9: size = 11'd1024;
			default: size = 11'($urandom_range(1, 1024));
			endcase
			if (phase == 2) base = 32'hFFFF_FE00;
			else if (phase == 6) base = 32'd0;
			else if (phase == 7) base = 32'hFFFF_FFFF;
			else base = $urandom;
			set_pool(base, size);
			for (k = 0; k < 116; k++) cmd_q.push_back(random_cmd());
			// Hold off the receiver while this phase is being sent.
			if (phase == 6) hold_asked++;
			drain();
		end

		$display("Sent %0d command beats: %0d set, %0d clear, %0d test,",
			act_beats[apbo_pkg::ACT_SET] + act_beats[apbo_pkg::ACT_CLEAR]
			+ act_beats[apbo_pkg::ACT_TEST] + act_beats[apbo_pkg::ACT_NEXT]
			+ act_beats[apbo_pkg::ACT_LAST] + act_beats[apbo_pkg::ACT_FULL]
			+ act_beats[ACT_SPARE_6] + act_beats[ACT_SPARE_7],
			act_beats[apbo_pkg::ACT_SET], act_beats[apbo_pkg::ACT_CLEAR],
			act_beats[apbo_pkg::ACT_TEST]);
		$display("%0d next, %0d last, %0d range checks, %0d unassigned codes,",
			act_beats[apbo_pkg::ACT_NEXT], act_beats[apbo_pkg::ACT_LAST],
			act_beats[apbo_pkg::ACT_FULL], act_beats[ACT_SPARE_6] + act_beats[ACT_SPARE_7]);
		$display("over %0d pool settings; %0d results checked, %0d mismatches.",
			pool_settings, results_checked, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
src/apbo_pkg.sv
src/apbo_ram.sv
src/apbo_divider.sv
src/apbo_regs.sv
src/address_pool_bitmap_offer.sv
tb/sv/tb_top.sv
